// File: src/ppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants for the proportional position drive.
// ----------------------------------------------------------------------------
package ppd_pkg;

   localparam int unsigned DutyWidth    = 8;
   localparam int unsigned PosWidth     = 8;
   localparam int unsigned TimeoutWidth = 16;
   localparam int unsigned RevWidth     = 8;
   localparam int unsigned GainWidth    = 4;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   // Largest error (255) shifted by the largest gain (15) fits in 23 bits.
   localparam int unsigned MagWidth = PosWidth + (1 << GainWidth) - 1;

   localparam logic [DutyWidth-1:0]    DUTY_MAX        = 8'd255;
   localparam logic [TimeoutWidth-1:0] RESET_TIMEOUT   = 16'd1000;
   localparam logic [RevWidth-1:0]     RESET_REVERSALS = 8'd3;
   localparam logic [GainWidth-1:0]    RESET_GAIN      = 4'd5;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TIMEOUT_TICKS = 2'd0,
      CSR_MAX_REVERSALS = 2'd1,
      CSR_GAIN_SHIFT    = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_TICK     = 1'b0,
      FUNC_SETPOINT = 1'b1
   } func_type;

endpackage

// File: src/proportional_position_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proportional_position_drive
// Proportional position regulator for one motor channel with timeout and
// reversal budgets.
// ----------------------------------------------------------------------------
// Each transaction is decoded straight off the request ports, the regulator
// state is updated at the accepting edge and the result lands in the response
// register at that same edge. A new request is taken every clock as long as
// the response register is empty or is being drained in that cycle, so the
// block sustains one transaction per clock; apart from reset, the response
// register is the only thing that can hold it up. Configuration writes only
// change the budget reload values and the gain; running budgets pick up new
// limits at the next set-point change.
module proportional_position_drive (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [ppd_pkg::PosWidth-1:0]        req_position,
   input  logic [ppd_pkg::PosWidth-1:0]        req_setpoint,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ppd_pkg::DutyWidth-1:0]       rsp_pwm,
   output logic                                rsp_direction,
   output logic                                rsp_halted,
   // configuration port
   input  logic                                csr_write,
   input  logic [ppd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [ppd_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import ppd_pkg::*;

   // ---- configuration registers ----
   logic [TimeoutWidth-1:0] timeout_ticks_ff;
   logic [RevWidth-1:0]     max_reversals_ff;
   logic [GainWidth-1:0]    gain_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= RESET_TIMEOUT;
         max_reversals_ff <= RESET_REVERSALS;
         gain_shift_ff    <= RESET_GAIN;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata[TimeoutWidth-1:0];
            CSR_MAX_REVERSALS: max_reversals_ff <= csr_wdata[RevWidth-1:0];
            CSR_GAIN_SHIFT:    gain_shift_ff    <= csr_wdata[GainWidth-1:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // ---- regulator state ----
   logic [PosWidth-1:0]     target_ff,         target_in;
   logic [DutyWidth-1:0]    duty_ff,           duty_in;
   logic                    dir_ff,            dir_in;
   logic [TimeoutWidth-1:0] timeout_left_ff,   timeout_left_in;
   logic [RevWidth-1:0]     reversals_left_ff, reversals_left_in;

   // ---- response register ----
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [DutyWidth-1:0]    rsp_pwm_ff;
   logic                    rsp_dir_ff;
   logic                    rsp_halted_ff;

   logic req_accept;
   logic rsp_accept;
   logic budget_spent;
   logic halted_next;
   logic err_fwd;
   logic [PosWidth-1:0]  err_mag;
   logic [MagWidth-1:0]  mag_shifted;
   logic [DutyWidth-1:0] mag_sat;

   // Stall while a finished result is still waiting downstream, and during reset.
   assign req_stall  = reset | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;

   assign budget_spent = (timeout_left_ff == '0) | (reversals_left_ff == '0);

   // Error magnitude and direction; zero error counts as forward.
   always_comb begin
      err_fwd     = (target_ff >= req_position);
      err_mag     = err_fwd ? (target_ff - req_position) : (req_position - target_ff);
      mag_shifted = {{(MagWidth-PosWidth){1'b0}}, err_mag} << gain_shift_ff;
      mag_sat     = (mag_shifted > MagWidth'(DUTY_MAX)) ? DUTY_MAX
                                                        : mag_shifted[DutyWidth-1:0];
   end

   // Next regulator state for the transaction being accepted.
   always_comb begin
      target_in         = target_ff;
      duty_in           = duty_ff;
      dir_in            = dir_ff;
      timeout_left_in   = timeout_left_ff;
      reversals_left_in = reversals_left_ff;
      if (req_accept) begin
         case (func_type'(req_func))
            FUNC_SETPOINT: begin
               // Only a changed target reloads the budgets.
               if (req_setpoint != target_ff) begin
                  timeout_left_in   = timeout_ticks_ff;
                  reversals_left_in = max_reversals_ff;
               end
               target_in = req_setpoint;
            end
            FUNC_TICK: begin
               if (budget_spent) begin
                  duty_in = '0;   // drive cut, direction held
               end else begin
                  if (err_fwd != dir_ff)
                     reversals_left_in = reversals_left_ff - 1'b1;
                  duty_in         = mag_sat;
                  dir_in          = err_fwd;
                  timeout_left_in = timeout_left_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign halted_next  = (timeout_left_in == '0) | (reversals_left_in == '0);
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff         <= '0;
         duty_ff           <= '0;
         dir_ff            <= 1'b0;
         timeout_left_ff   <= RESET_TIMEOUT;
         reversals_left_ff <= RESET_REVERSALS;
         rsp_valid_ff      <= 1'b0;
      end else begin
         target_ff         <= target_in;
         duty_ff           <= duty_in;
         dir_ff            <= dir_in;
         timeout_left_ff   <= timeout_left_in;
         reversals_left_ff <= reversals_left_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload loads only on accept, so a stalled result holds.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_pwm_ff    <= duty_in;
         rsp_dir_ff    <= dir_in;
         rsp_halted_ff <= halted_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pwm       = rsp_pwm_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_halted    = rsp_halted_ff;

   // ---- assertions ----
   // A tick taken with a spent budget must report zero duty.
   a_cut_drive: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_func == FUNC_TICK) && budget_spent
      |=> rsp_valid && (rsp_pwm == '0) && rsp_halted)
      else $error("tick with spent budget did not cut drive");

   // An active tick spends exactly one timeout unit.
   a_timeout_step: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_func == FUNC_TICK) && !budget_spent
      |=> timeout_left_ff == $past(timeout_left_ff) - 1'b1)
      else $error("timeout budget not decremented by one");

   // Without an accepted transaction the regulator state stays put.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(target_ff) && $stable(timeout_left_ff)
                      && $stable(reversals_left_ff) && $stable(dir_ff))
      else $error("regulator state changed without a transaction");

   // A result waiting downstream must not be overwritten or dropped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_pwm_ff)
                                    && $stable(rsp_halted_ff))
      else $error("stalled result lost");

endmodule
